@@ sv/wtd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtd_pkg
// Shared types and constants of the weighted table draw block.
// ----------------------------------------------------------------------------
package wtd_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int WEIGHT_BITS = 16;
    localparam int VALUE_BITS  = 16;

    localparam int FRAC_BITS   = 16;
    localparam int RARITY_BITS = 17;
    localparam logic [RARITY_BITS-1:0] RARITY_ONE = 17'h10000;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_DRAW  = 2'd2,
        OP_RARE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR_ACC,
        S_RANK,
        S_QUANT,
        S_THR,
        S_CUM,
        S_TARGET,
        S_PLAIN,
        S_SELECT,
        S_DONE
    } state_t;

    // controls broadcast to every cell of the ring
    typedef struct packed {
        logic shift;
        logic clear_acc;
        logic rank_en;
        logic cum_en;
    } cell_ctrl_t;

endpackage
`default_nettype wire

@@ sv/wtd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtd_if
// Valid/ready channels of the weighted table draw block.
// ----------------------------------------------------------------------------
interface wtd_in_if #(
    parameter int WEIGHT_BITS = wtd_pkg::WEIGHT_BITS,
    parameter int VALUE_BITS  = wtd_pkg::VALUE_BITS
);
    logic                               valid;
    logic                               ready;
    logic [1:0]                         operation;
    logic [WEIGHT_BITS-1:0]             weight;
    logic [VALUE_BITS-1:0]              item_value;
    logic [wtd_pkg::FRAC_BITS-1:0]      random_fraction;
    logic [wtd_pkg::RARITY_BITS-1:0]    rarity;

    modport source (output valid, operation, weight, item_value, random_fraction, rarity,
                    input ready);
    modport sink   (input valid, operation, weight, item_value, random_fraction, rarity,
                    output ready);
endinterface

interface wtd_out_if #(
    parameter int VALUE_BITS = wtd_pkg::VALUE_BITS
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] picked_value;
    logic [1:0]            status;

    modport source (output valid, picked_value, status, input ready);
    modport sink   (input valid, picked_value, status, output ready);
endinterface
`default_nettype wire

@@ sv/wtd_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtd_cell
// One table entry of the rotating ring, with its rank and running sum.
// ----------------------------------------------------------------------------
module wtd_cell #(
    parameter int WEIGHT_BITS = wtd_pkg::WEIGHT_BITS,
    parameter int VALUE_BITS  = wtd_pkg::VALUE_BITS,
    parameter int IDX_W       = 8,
    parameter int SUM_W       = 24,
    parameter int POS         = 0
) (
    input  logic                    clk,
    input  wtd_pkg::cell_ctrl_t     ctrl,
    input  logic                    wr_en,
    input  logic [WEIGHT_BITS-1:0]  wr_weight,
    input  logic [VALUE_BITS-1:0]   wr_value,
    input  logic [WEIGHT_BITS-1:0]  head_weight,
    input  logic [IDX_W-1:0]        head_idx,
    input  logic                    head_pos,
    input  logic                    head_kept,
    input  logic [WEIGHT_BITS-1:0]  nb_weight,
    input  logic [VALUE_BITS-1:0]   nb_value,
    input  logic [IDX_W-1:0]        nb_idx,
    input  logic [IDX_W-1:0]        nb_rank,
    input  logic [SUM_W-1:0]        nb_cum,
    output logic [WEIGHT_BITS-1:0]  weight,
    output logic [VALUE_BITS-1:0]   value,
    output logic [IDX_W-1:0]        idx,
    output logic [IDX_W-1:0]        rank,
    output logic [SUM_W-1:0]        cum
);

    logic [WEIGHT_BITS-1:0] weight_reg;
    logic [VALUE_BITS-1:0]  value_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       rank_reg;
    logic [SUM_W-1:0]       cum_reg;

    logic                   head_first;
    logic                   head_same;
    logic [IDX_W-1:0]       rank_next;
    logic [SUM_W-1:0]       cum_next;

    // head orders before the incoming entry: by weight, then by insertion
    assign head_first = (head_weight < nb_weight) ||
                        ((head_weight == nb_weight) && (head_idx < nb_idx));
    assign head_same  = (head_idx == nb_idx);

    always_comb
    begin
        rank_next = nb_rank;
        cum_next  = nb_cum;
        if (ctrl.rank_en && head_pos && head_first)
        begin
            rank_next = nb_rank + IDX_W'(1);
        end
        if (ctrl.cum_en && head_kept && (head_first || head_same))
        begin
            cum_next = nb_cum + SUM_W'(head_weight);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            weight_reg <= wr_weight;
            value_reg  <= wr_value;
            idx_reg    <= IDX_W'(POS);
        end
        else if (ctrl.clear_acc)
        begin
            rank_reg <= '0;
            cum_reg  <= '0;
        end
        else if (ctrl.shift)
        begin
            weight_reg <= nb_weight;
            value_reg  <= nb_value;
            idx_reg    <= nb_idx;
            rank_reg   <= rank_next;
            cum_reg    <= cum_next;
        end
    end

    assign weight = weight_reg;
    assign value  = value_reg;
    assign idx    = idx_reg;
    assign rank   = rank_reg;
    assign cum    = cum_reg;

endmodule
`default_nettype wire

@@ sv/weighted_table_draw.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_table_draw
// Weighted value table with inverse-CDF draw and rare draw.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one item per valid/ready handshake: clear, add entry, draw or
//   rare draw. rsp returns exactly one item for each command: picked_value
//   and status (ok, table empty on a draw, table full with the add dropped).
//   The table is a ring of TABLE_DEPTH cells. Each pass of a draw rotates
//   the ring once, so the head cell sees every entry in insertion order;
//   at the end of a pass the ring is back in place.
//   Clear, add and a draw on an empty table answer in the next cycle. A draw
//   registers its target, then scans the ring; a rare draw first clears
//   its sums and runs rank, threshold and running sum passes, then a select
//   pass, or a plain draw when no weight is positive. Clear and add run back
//   to back; a draw frees cmd in the same cycle as its item, if rsp is ready.
//   cmd.ready is high when the sequencer is idle and the output register is
//   empty or being drained. A stalled rsp holds its item; a finished draw
//   then waits in the done state until the output register frees.
//   Reset empties the table (count and total to zero) and drops any pending
//   rsp item; cell contents are not cleared.
// ----------------------------------------------------------------------------
module weighted_table_draw #(
    parameter int TABLE_DEPTH = wtd_pkg::TABLE_DEPTH,
    parameter int WEIGHT_BITS = wtd_pkg::WEIGHT_BITS,
    parameter int VALUE_BITS  = wtd_pkg::VALUE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    wtd_in_if.sink      cmd,
    wtd_out_if.source   rsp
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W  = WEIGHT_BITS + IDX_W;
    localparam int FRAC   = wtd_pkg::FRAC_BITS;
    localparam int RBITS  = wtd_pkg::RARITY_BITS;
    localparam int TPROD_W = FRAC + SUM_W;
    localparam int QPROD_W = CNT_W + RBITS;
    localparam logic [IDX_W-1:0] LAST_K = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    // control state
    wtd_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SUM_W-1:0]       total_reg, total_next;
    logic                   out_valid_reg, out_valid_next;

    // datapath
    logic [IDX_W-1:0]       k_reg, k_next;
    logic [CNT_W-1:0]       m_reg, m_next;
    logic [WEIGHT_BITS-1:0] minw_reg, minw_next;
    logic [IDX_W-1:0]       p_reg, p_next;
    logic [WEIGHT_BITS-1:0] thr_reg, thr_next;
    logic [SUM_W-1:0]       kept_reg, kept_next;
    logic [SUM_W-1:0]       target_reg, target_next;
    logic [SUM_W-1:0]       run_reg, run_next;
    logic [SUM_W-1:0]       best_reg, best_next;
    logic                   found_reg, found_next;
    logic [VALUE_BITS-1:0]  res_reg, res_next;
    logic                   rare_reg, rare_next;
    logic [FRAC-1:0]        rnd_reg, rnd_next;
    logic [RBITS-1:0]       rarity_reg, rarity_next;
    logic [VALUE_BITS-1:0]  out_value_reg, out_value_next;
    logic [1:0]             out_status_reg, out_status_next;

    // ring of cells, index 0 is the head
    logic [WEIGHT_BITS-1:0] ent_weight [TABLE_DEPTH];
    logic [VALUE_BITS-1:0]  ent_value  [TABLE_DEPTH];
    logic [IDX_W-1:0]       ent_idx    [TABLE_DEPTH];
    logic [IDX_W-1:0]       ent_rank   [TABLE_DEPTH];
    logic [SUM_W-1:0]       ent_cum    [TABLE_DEPTH];

    wtd_pkg::cell_ctrl_t    ctrl;
    logic                   add_wr;

    logic                   accept;
    logic                   out_free;
    logic                   head_live;
    logic                   head_pos;
    logic                   head_kept;
    logic                   pass_end;
    logic [SUM_W-1:0]       run_sum;
    logic [SUM_W-1:0]       sum_sel;
    logic [TPROD_W-1:0]     tprod;
    logic [RBITS-1:0]       rar_clamped;
    logic [QPROD_W-1:0]     qprod;
    logic [CNT_W:0]         p_full;
    logic [CNT_W-1:0]       m_less;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == wtd_pkg::S_IDLE) && out_free;
    assign accept    = cmd.valid && cmd.ready;

    // head of the ring holds the entry inserted k_reg-th during a pass
    assign head_live = CNT_W'(k_reg) < count_reg;
    assign head_pos  = head_live && (ent_weight[0] != '0);
    assign head_kept = head_pos && ((ent_weight[0] < thr_reg) ||
                       ((thr_reg == minw_reg) && (ent_weight[0] == minw_reg)));
    assign pass_end  = (k_reg == LAST_K);
    assign run_sum   = run_reg + (head_live ? SUM_W'(ent_weight[0]) : '0);

    // draw target, registered before the scan pass
    assign sum_sel = rare_reg ? kept_reg : total_reg;
    assign tprod   = TPROD_W'(rnd_reg) * TPROD_W'(sum_sel);

    // rare-draw quantile position, clamped to the last positive entry
    assign rar_clamped = (rarity_reg > wtd_pkg::RARITY_ONE) ? wtd_pkg::RARITY_ONE
                                                            : rarity_reg;
    assign qprod  = QPROD_W'(m_reg) * QPROD_W'(rar_clamped);
    assign p_full = qprod[QPROD_W-1:FRAC];
    assign m_less = m_reg - CNT_W'(1);

    genvar j;
    generate
        for (j = 0; j < TABLE_DEPTH; j++)
        begin : g_cell
            localparam int NB = (j + 1) % TABLE_DEPTH;
            logic wr_here;

            assign wr_here = add_wr && (count_reg == CNT_W'(j));

            wtd_cell #(
                .WEIGHT_BITS (WEIGHT_BITS),
                .VALUE_BITS  (VALUE_BITS),
                .IDX_W       (IDX_W),
                .SUM_W       (SUM_W),
                .POS         (j)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .wr_en       (wr_here),
                .wr_weight   (cmd.weight),
                .wr_value    (cmd.item_value),
                .head_weight (ent_weight[0]),
                .head_idx    (k_reg),
                .head_pos    (head_pos),
                .head_kept   (head_kept),
                .nb_weight   (ent_weight[NB]),
                .nb_value    (ent_value[NB]),
                .nb_idx      (ent_idx[NB]),
                .nb_rank     (ent_rank[NB]),
                .nb_cum      (ent_cum[NB]),
                .weight      (ent_weight[j]),
                .value       (ent_value[j]),
                .idx         (ent_idx[j]),
                .rank        (ent_rank[j]),
                .cum         (ent_cum[j])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        k_next          = k_reg;
        m_next          = m_reg;
        minw_next       = minw_reg;
        p_next          = p_reg;
        thr_next        = thr_reg;
        kept_next       = kept_reg;
        target_next     = target_reg;
        run_next        = run_reg;
        best_next       = best_reg;
        found_next      = found_reg;
        res_next        = res_reg;
        rare_next       = rare_reg;
        rnd_next        = rnd_reg;
        rarity_next     = rarity_reg;
        ctrl            = '0;
        add_wr          = 1'b0;

        case (state_reg)
            wtd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    rnd_next    = cmd.random_fraction;
                    rarity_next = cmd.rarity;
                    k_next      = '0;
                    case (wtd_pkg::op_t'(cmd.operation))
                        wtd_pkg::OP_CLEAR:
                        begin
                            count_next      = '0;
                            total_next      = '0;
                            out_valid_next  = 1'b1;
                            out_value_next  = '0;
                            out_status_next = wtd_pkg::ST_OK;
                        end
                        wtd_pkg::OP_ADD:
                        begin
                            out_valid_next = 1'b1;
                            out_value_next = '0;
                            if (count_reg == FULL_COUNT)
                            begin
                                out_status_next = wtd_pkg::ST_FULL;
                            end
                            else
                            begin
                                add_wr          = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                                total_next      = total_reg + SUM_W'(cmd.weight);
                                out_status_next = wtd_pkg::ST_OK;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_value_next  = '0;
                                out_status_next = wtd_pkg::ST_EMPTY;
                            end
                            else if (cmd.operation == wtd_pkg::OP_DRAW)
                            begin
                                rare_next  = 1'b0;
                                state_next = wtd_pkg::S_TARGET;
                            end
                            else
                            begin
                                rare_next  = 1'b1;
                                m_next     = '0;
                                state_next = wtd_pkg::S_CLR_ACC;
                            end
                        end
                    endcase
                end
            end

            wtd_pkg::S_CLR_ACC:
            begin
                ctrl.clear_acc = 1'b1;
                state_next     = wtd_pkg::S_RANK;
            end

            wtd_pkg::S_RANK:
            begin
                // rank every entry against the head; count positives, track minimum
                ctrl.shift   = 1'b1;
                ctrl.rank_en = 1'b1;
                if (head_pos)
                begin
                    m_next = m_reg + CNT_W'(1);
                    if ((m_reg == '0) || (ent_weight[0] < minw_reg))
                    begin
                        minw_next = ent_weight[0];
                    end
                end
                k_next = k_reg + IDX_W'(1);
                if (pass_end)
                begin
                    k_next     = '0;
                    state_next = wtd_pkg::S_QUANT;
                end
            end

            wtd_pkg::S_QUANT:
            begin
                kept_next = '0;
                if (m_reg == '0)
                begin
                    // no positive weight: fall back to a plain draw
                    rare_next  = 1'b0;
                    state_next = wtd_pkg::S_TARGET;
                end
                else
                begin
                    if (p_full > (CNT_W + 1)'(m_less))
                    begin
                        p_next = IDX_W'(m_less);
                    end
                    else
                    begin
                        p_next = IDX_W'(p_full);
                    end
                    state_next = wtd_pkg::S_THR;
                end
            end

            wtd_pkg::S_THR:
            begin
                ctrl.shift = 1'b1;
                if (head_pos && (ent_rank[0] == p_reg))
                begin
                    thr_next = ent_weight[0];
                end
                k_next = k_reg + IDX_W'(1);
                if (pass_end)
                begin
                    k_next     = '0;
                    state_next = wtd_pkg::S_CUM;
                end
            end

            wtd_pkg::S_CUM:
            begin
                // every entry sums the kept weights that order up to itself
                ctrl.shift  = 1'b1;
                ctrl.cum_en = 1'b1;
                if (head_kept)
                begin
                    kept_next = kept_reg + SUM_W'(ent_weight[0]);
                end
                k_next = k_reg + IDX_W'(1);
                if (pass_end)
                begin
                    k_next     = '0;
                    state_next = wtd_pkg::S_TARGET;
                end
            end

            wtd_pkg::S_TARGET:
            begin
                target_next = tprod[TPROD_W-1:FRAC];
                run_next    = '0;
                found_next  = 1'b0;
                res_next    = '0;
                k_next      = '0;
                state_next  = rare_reg ? wtd_pkg::S_SELECT : wtd_pkg::S_PLAIN;
            end

            wtd_pkg::S_PLAIN:
            begin
                // first entry defaults the pick when no running sum passes the target
                ctrl.shift = 1'b1;
                run_next   = run_sum;
                if (k_reg == '0)
                begin
                    res_next   = ent_value[0];
                    found_next = run_sum > target_reg;
                end
                else if (head_live && !found_reg && (run_sum > target_reg))
                begin
                    res_next   = ent_value[0];
                    found_next = 1'b1;
                end
                k_next = k_reg + IDX_W'(1);
                if (pass_end)
                begin
                    k_next     = '0;
                    state_next = wtd_pkg::S_DONE;
                end
            end

            wtd_pkg::S_SELECT:
            begin
                // smallest running sum above the target wins
                ctrl.shift = 1'b1;
                if (head_kept && (ent_cum[0] > target_reg) &&
                    (!found_reg || (ent_cum[0] < best_reg)))
                begin
                    best_next  = ent_cum[0];
                    res_next   = ent_value[0];
                    found_next = 1'b1;
                end
                k_next = k_reg + IDX_W'(1);
                if (pass_end)
                begin
                    k_next     = '0;
                    state_next = wtd_pkg::S_DONE;
                end
            end

            wtd_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_reg;
                    out_status_next = wtd_pkg::ST_OK;
                    state_next      = wtd_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = wtd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wtd_pkg::S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        m_reg          <= m_next;
        minw_reg       <= minw_next;
        p_reg          <= p_next;
        thr_reg        <= thr_next;
        kept_reg       <= kept_next;
        target_reg     <= target_next;
        run_reg        <= run_next;
        best_reg       <= best_next;
        found_reg      <= found_next;
        res_reg        <= res_next;
        rare_reg       <= rare_next;
        rnd_reg        <= rnd_next;
        rarity_reg     <= rarity_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.picked_value = out_value_reg;
    assign rsp.status       = out_status_reg;

endmodule
`default_nettype wire

@@ sv/wtd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtd_checker
// Port-level checks of the weighted table draw block.
// ----------------------------------------------------------------------------
module wtd_checker #(
    parameter int VALUE_BITS = wtd_pkg::VALUE_BITS
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cmd_valid,
    input logic                  cmd_ready,
    input logic [1:0]            cmd_operation,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [VALUE_BITS-1:0] rsp_picked_value,
    input logic [1:0]            rsp_status
);

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_picked_value) &&
                                    $stable(rsp_status))
        else $error("stalled rsp item changed");

    // never take a command while a response is stuck
    a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |-> !(rsp_valid && !rsp_ready))
        else $error("cmd accepted while rsp stalled");

    // clear answers in the next cycle with ok and zero
    a_clear_resp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_operation == wtd_pkg::OP_CLEAR) |=>
        rsp_valid && (rsp_status == wtd_pkg::ST_OK) && (rsp_picked_value == '0))
        else $error("clear response wrong");

    // only an ok status carries a picked value
    a_zero_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != wtd_pkg::ST_OK) |-> rsp_picked_value == '0)
        else $error("nonzero value with error status");

endmodule

bind weighted_table_draw wtd_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_wtd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd.valid),
    .cmd_ready        (cmd.ready),
    .cmd_operation    (cmd.operation),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_picked_value (rsp.picked_value),
    .rsp_status       (rsp.status)
);
`default_nettype wire
